@@ rtl/rau_pkg.sv @@
// Shared types and codes for the rational arithmetic unit.
// Used by every module of the block; depends on nothing.
package rau_pkg;

  localparam int MAG_W = 63;          // magnitude of any cross product or sum
  localparam int N_W   = MAG_W + 1;   // signed cross product or sum
  localparam int CNT_W = 6;           // holds a bit index of a magnitude

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_EQ  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_equal;
    logic [1:0]         status;
  } rau_out_t;

  typedef enum logic {JOB_CONST, JOB_REDUCE} rau_cls_t;

  typedef struct packed {
    rau_cls_t              cls;
    logic signed [N_W-1:0] n;
    logic [MAG_W-1:0]      d;
    rau_out_t              res;
  } rau_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rau_qstat_t;

endpackage

@@ rtl/rau_queue.sv @@
// Two-entry job queue between the front and back parts.
// Depends on rau_pkg for the job and status types.
module rau_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rau_pkg::rau_job_t push_job,
  input  logic              pop,
  output rau_pkg::rau_job_t pop_job,
  output rau_pkg::rau_qstat_t stat
);
  import rau_pkg::*;

  rau_job_t   mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign pop_job    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !stat.full) begin
        wptr <= ~wptr;
      end
      if (pop && !stat.empty) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push && !stat.full} - {1'b0, pop && !stat.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      mem[wptr] <= push_job;
    end
  end

endmodule

@@ rtl/rau_front.sv @@
// Front part: accepts an operation, forms the cross products on one
// multiplier, classifies the job and pushes it into the queue. Uses rau_pkg.
module rau_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rau_pkg::rau_in_t    op,
  output logic                push,
  output rau_pkg::rau_job_t   push_job,
  input  rau_pkg::rau_qstat_t stat
);
  import rau_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

  fstate_t               state;
  rau_in_t               opr;
  logic                  cst;
  logic [1:0]            cst_st;
  logic [1:0]            step;
  logic signed [N_W-1:0] p0, p1, p2;
  logic signed [32:0]    ma, mb;
  logic signed [65:0]    prod;
  logic [1:0]            last_step;
  logic                  den_zero;

  assign busy      = (state != F_IDLE);
  assign den_zero  = (op.a_den == '0) || (op.b_den == '0);
  assign last_step = ((opr.kind == KIND_ADD) || (opr.kind == KIND_SUB)) ? 2'd2 : 2'd1;

  always_comb begin
    ma = {opr.a_num[31], opr.a_num};
    mb = {2'b00, opr.b_den};
    case (step)
      2'd0: begin
        ma = {opr.a_num[31], opr.a_num};
        mb = (opr.kind == KIND_MUL) ? {opr.b_num[31], opr.b_num} : {2'b00, opr.b_den};
      end
      2'd1: begin
        ma = (opr.kind == KIND_MUL) ? {2'b00, opr.a_den} : {opr.b_num[31], opr.b_num};
        mb = (opr.kind == KIND_MUL) ? {2'b00, opr.b_den} : {2'b00, opr.a_den};
      end
      default: begin
        ma = {2'b00, opr.a_den};
        mb = {2'b00, opr.b_den};
      end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    push_job         = '0;
    push_job.cls     = JOB_CONST;
    push_job.res.res_den = 31'd1;
    push_job.res.status  = ST_OK;
    if (cst) begin
      push_job.res.status = cst_st;
    end else begin
      case (opr.kind)
        KIND_ADD: begin
          push_job.cls = JOB_REDUCE;
          push_job.n   = p0 + p1;
          push_job.d   = p2[MAG_W-1:0];
        end
        KIND_SUB: begin
          push_job.cls = JOB_REDUCE;
          push_job.n   = p0 - p1;
          push_job.d   = p2[MAG_W-1:0];
        end
        KIND_MUL: begin
          push_job.cls = JOB_REDUCE;
          push_job.n   = p0;
          push_job.d   = p1[MAG_W-1:0];
        end
        KIND_DIV: begin
          // move the sign of the denominator onto the numerator
          push_job.cls = JOB_REDUCE;
          push_job.n   = p1[N_W-1] ? -p0 : p0;
          push_job.d   = p1[N_W-1] ? MAG_W'(-p1) : p1[MAG_W-1:0];
        end
        KIND_EQ: begin
          push_job.res.is_equal = (p0 == p1);
        end
        default: begin
        end
      endcase
    end
  end

  assign push = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            opr    <= op;
            step   <= 2'd0;
            cst    <= 1'b0;
            cst_st <= ST_OK;
            if (den_zero || ((op.kind == KIND_DIV) && (op.b_num == '0))) begin
              cst    <= 1'b1;
              cst_st <= ST_DIVZ;
              state  <= F_PUSH;
            end else if (op.kind > KIND_EQ) begin
              cst   <= 1'b1;
              state <= F_PUSH;
            end else begin
              state <= F_MUL;
            end
          end
        end
        F_MUL: begin
          case (step)
            2'd0:    p0 <= prod[N_W-1:0];
            2'd1:    p1 <= prod[N_W-1:0];
            default: p2 <= prod[N_W-1:0];
          endcase
          step <= step + 2'd1;
          if (step == last_step) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!stat.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/rau_back.sv @@
// Back part: pops jobs, reduces by a binary GCD, divides both terms by the
// GCD one quotient bit a cycle and checks the range. Uses rau_pkg.
module rau_back (
  input  logic                clk,
  input  logic                rst,
  output logic                pop,
  input  rau_pkg::rau_job_t   pop_job,
  input  rau_pkg::rau_qstat_t stat,
  output logic                done,
  output rau_pkg::rau_out_t   result
);
  import rau_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_TWOS, B_GCD, B_DIVN, B_DIVD, B_FIN} bstate_t;

  localparam logic [MAG_W-1:0] MAX_POS = MAG_W'(32'h7FFF_FFFF);
  localparam logic [MAG_W-1:0] MAX_NEG = MAG_W'(32'h8000_0000);

  bstate_t          state;
  logic             neg;
  logic [MAG_W-1:0] mag, den, x, y, g, q, qn, qd;
  logic [MAG_W:0]   rem, rs, diff;
  logic [CNT_W-1:0] k, cnt;
  logic [MAG_W-1:0] q_next;
  logic [MAG_W:0]   rem_next;
  logic             ovf;
  logic [MAG_W-1:0] abs_n;

  assign pop   = (state == B_IDLE) && !stat.empty;
  assign abs_n = pop_job.n[N_W-1] ? MAG_W'(-pop_job.n) : pop_job.n[MAG_W-1:0];

  // one restoring division step
  always_comb begin
    rs   = {rem[MAG_W-1:0], q[MAG_W-1]};
    diff = rs - {1'b0, g};
    if (!diff[MAG_W] || rs[MAG_W]) begin
      rem_next = diff;
      q_next   = {q[MAG_W-2:0], 1'b1};
    end else begin
      rem_next = rs;
      q_next   = {q[MAG_W-2:0], 1'b0};
    end
  end

  assign ovf = (qd > MAX_POS) || (neg ? (qn > MAX_NEG) : (qn > MAX_POS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!stat.empty) begin
            if (pop_job.cls == JOB_CONST) begin
              result <= pop_job.res;
              done   <= 1'b1;
            end else begin
              neg   <= pop_job.n[N_W-1];
              mag   <= abs_n;
              den   <= pop_job.d;
              x     <= abs_n;
              y     <= pop_job.d;
              k     <= '0;
              state <= B_TWOS;
            end
          end
        end
        B_TWOS: begin
          // strip common factors of two
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else begin
            state <= B_GCD;
          end
        end
        B_GCD: begin
          if (x == '0) begin
            g     <= y << k;
            q     <= mag;
            rem   <= '0;
            cnt   <= '0;
            state <= B_DIVN;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x >= y) begin
            x <= (x - y) >> 1;
          end else begin
            y <= (y - x) >> 1;
          end
        end
        B_DIVN: begin
          q   <= q_next;
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MAG_W - 1)) begin
            qn    <= q_next;
            q     <= den;
            rem   <= '0;
            cnt   <= '0;
            state <= B_DIVD;
          end
        end
        B_DIVD: begin
          q   <= q_next;
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MAG_W - 1)) begin
            qd    <= q_next;
            state <= B_FIN;
          end
        end
        B_FIN: begin
          result.is_equal <= 1'b0;
          if (ovf) begin
            result.res_num <= '0;
            result.res_den <= 31'd1;
            result.status  <= ST_OVF;
          end else begin
            result.res_num <= neg ? -qn[31:0] : qn[31:0];
            result.res_den <= qd[30:0];
            result.status  <= ST_OK;
          end
          done  <= 1'b1;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/rational_arithmetic_unit_core.sv @@
// Rational arithmetic unit, top level.
// Depends on rau_pkg, rau_front, rau_queue and rau_back.
//
// Usage: drive op (kind, a_num, a_den, b_num, b_den) and raise start; the beat
// is taken at the rising edge where start is high and busy is low. Each beat
// yields exactly one result beat on result, marked by done for one cycle.
// The receiver cannot stall; results are never held back.
// The front is busy while it forms the products (one shared 33x33 multiplier,
// one product a cycle) and until the job enters a two-entry queue, so it can
// take new beats while the back end works. The back end sets the rate: a binary
// GCD, then two restoring divisions by the GCD and a range check.
// Constant results (zero denominator, division by zero, equality test, unused
// kinds) skip the GCD and divisions and leave the back end from its idle state.
// Reset clears the queue and both sequencers; no result is pending after it.
module rational_arithmetic_unit_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_in_t  op,
  output logic              done,
  output rau_pkg::rau_out_t result
);
  import rau_pkg::*;

  logic       push, pop;
  rau_job_t   push_job, pop_job;
  rau_qstat_t stat;

  rau_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .push(push), .push_job(push_job), .stat(stat)
  );

  rau_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job),
    .pop(pop), .pop_job(pop_job), .stat(stat)
  );

  rau_back u_back (
    .clk(clk), .rst(rst), .pop(pop), .pop_job(pop_job), .stat(stat),
    .done(done), .result(result)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |-> (result.res_num == '0 && result.res_den == 31'd1))
    else $error("error result not 0/1");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.res_den != '0))
    else $error("zero result denominator");

  a_no_done_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the rational arithmetic unit: directed and random fraction beats,
// checked against an in-bench predictor. Depends on rau_pkg and
// rational_arithmetic_unit_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  rau_in_t  op;
  logic     done;
  rau_out_t result;

  rau_in_t  pending_ops[$];
  rau_out_t expected_results[$];
  int       mismatch_cnt;
  int       gap_left;
  bit       hold_for_drain;
  longint   cycle_cnt;
  bit       stim_done;

  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  rational_arithmetic_unit_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned gcd_u(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Reduce n/d in place; d is positive.
  function automatic void reduce_frac(inout longint n, inout longint d);
    longint unsigned g;
    longint unsigned mag;
    mag = (n < 0) ? longint'(-n) : n;
    g = gcd_u(mag, d);
    if (g == 0) g = 1;
    n = n / longint'(g);
    d = d / longint'(g);
  endfunction

  function automatic rau_out_t predict_fraction(rau_in_t x);
    rau_out_t r;
    longint an, ad, bn, bd, n, d, n1, d1, n2, d2;
    bit have;
    an = longint'(x.a_num); ad = longint'({1'b0, x.a_den});
    bn = longint'(x.b_num); bd = longint'({1'b0, x.b_den});
    n = 0; d = 1; have = 0;
    r.is_equal = 1'b0;
    r.status = ST_OK;
    if (ad == 0 || bd == 0) begin
      r.status = ST_DIVZ;
    end else begin
      case (x.kind)
        KIND_ADD: begin n = an * bd + bn * ad; d = ad * bd; have = 1; end
        KIND_SUB: begin n = an * bd - bn * ad; d = ad * bd; have = 1; end
        KIND_MUL: begin n = an * bn; d = ad * bd; have = 1; end
        KIND_DIV: begin
          if (bn == 0) begin
            r.status = ST_DIVZ;
          end else begin
            n = an * bd;
            d = ad * bn;
            if (d < 0) begin n = -n; d = -d; end
            have = 1;
          end
        end
        KIND_EQ: begin
          n1 = an; d1 = ad; n2 = bn; d2 = bd;
          reduce_frac(n1, d1);
          reduce_frac(n2, d2);
          r.is_equal = (n1 == n2 && d1 == d2);
        end
        default: ;
      endcase
    end
    if (have) begin
      reduce_frac(n, d);
      if (n < -64'sd2147483648 || n > 64'sd2147483647 || d < 1 || d > 64'sd2147483647) begin
        r.status = ST_OVF;
        n = 0;
        d = 1;
      end
    end
    r.res_num = n[31:0];
    r.res_den = d[30:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 40)) - 20);
      4: return 32'($urandom_range(0, 2000)) - 32'd1000;
      5: return 32'($urandom_range(0, 1) ? 1 : -1) * (32'd1 << $urandom_range(0, 30));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    logic [30:0] v;
    case ($urandom_range(0, 6))
      0: v = 31'h7fff_ffff;
      1: v = 31'd1;
      2: v = 31'($urandom_range(1, 40));
      3: v = 31'($urandom_range(1, 5000));
      4: v = 31'd1 << $urandom_range(0, 30);
      default: v = 31'($urandom);
    endcase
    // Zero denominators are a legal special case but keep them rare.
    if (v == 0 || ($urandom_range(0, 60) != 0 && v == 0)) v = 31'd1;
    if ($urandom_range(0, 80) == 0) v = 31'd0;
    return v;
  endfunction

  task automatic add_op(logic [2:0] k, logic [31:0] an, logic [30:0] ad,
                        logic [31:0] bn, logic [30:0] bd);
    rau_in_t x;
    x.kind = k; x.a_num = an; x.a_den = ad; x.b_num = bn; x.b_den = bd;
    pending_ops.push_back(x);
  endtask

  initial begin
    rau_in_t x;
    int      m;
    add_op(KIND_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
    add_op(KIND_ADD, 32'd1, 31'd2, 32'd1, 31'd2);
    add_op(KIND_SUB, 32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'd1);
    add_op(KIND_SUB, 32'd3, 31'd7, 32'd3, 31'd7);
    add_op(KIND_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    add_op(KIND_MUL, 32'h8000_0000, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    add_op(KIND_MUL, -32'sd6, 31'd35, 32'd14, 31'd9);
    add_op(KIND_DIV, 32'd5, 31'd3, 32'd0, 31'd4);
    add_op(KIND_DIV, 32'd5, 31'd3, -32'sd10, 31'd9);
    add_op(KIND_DIV, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
    add_op(KIND_DIV, 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    add_op(KIND_EQ, 32'd2, 31'd4, 32'd1, 31'd2);
    add_op(KIND_EQ, 32'd0, 31'd5, 32'd0, 31'd9);
    add_op(KIND_EQ, -32'sd2, 31'd4, 32'd1, 31'd2);
    add_op(KIND_EQ, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    add_op(KIND_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
    add_op(KIND_EQ, 32'd1, 31'd1, 32'd1, 31'd0);
    add_op(KIND_DIV, 32'd0, 31'd0, 32'd0, 31'd0);
    add_op(3'd5, 32'd1, 31'd1, 32'd1, 31'd1);
    add_op(3'd6, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    add_op(3'd7, 32'd0, 31'd0, 32'd0, 31'd0);
    add_op(KIND_MUL, 32'd0, 31'd3, 32'd77, 31'd5);
    add_op(KIND_ADD, 32'd1, 31'h7fff_ffff, 32'd1, 31'h7fff_fffe);
    for (int i = 0; i < 1900; i++) begin
      m = $urandom_range(0, 19);
      x.kind = (m == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      x.a_num = pick_num();
      x.a_den = pick_den();
      x.b_num = pick_num();
      x.b_den = pick_den();
      if (x.kind == KIND_EQ && $urandom_range(0, 1)) begin
        // Scaled copy so equality often holds.
        m = $urandom_range(1, 9);
        x.a_num = 32'($signed($urandom_range(0, 2000)) - 1000);
        x.a_den = 31'($urandom_range(1, 1000));
        x.b_num = x.a_num * m;
        x.b_den = 31'(x.a_den * m);
        if ($urandom_range(0, 3) == 0) x.b_num = x.b_num + 1;
      end
      pending_ops.push_back(x);
    end
  end

  // Driver: present the next beat after a random gap, hold it until taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      op <= '0;
      gap_left <= 0;
      hold_for_drain <= 1'b0;
    end else if (start && !busy) begin
      start <= 1'b0;
      gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
      if (pending_ops.size() == 950) hold_for_drain <= 1'b1;
    end else if (!start) begin
      if (hold_for_drain) begin
        if (expected_results.size() == 0) hold_for_drain <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() != 0) begin
        op <= pending_ops[0];
        expected_results.push_back(predict_fraction(pending_ops[0]));
        pending_ops.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    rau_out_t exp_r;
    if (rst) begin
      mismatch_cnt <= 0;
    end else if (done) begin
      if (expected_results.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) $display("unexpected result beat %p", result);
      end else begin
        exp_r = expected_results.pop_front();
        if (result !== exp_r) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("mismatch: expected %p actual %p", exp_r, result);
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
    repeat (600) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
